>>> hw/rtl/ucdc_pkg.sv
// shared constants, codes and helpers for the unknown cell disk counter
package ucdc_pkg;

  localparam int unsigned MAX_MAP_WIDTH    = 1024;
  localparam int unsigned MAX_MAP_HEIGHT   = 1024;
  localparam int unsigned MAX_RADIUS_CELLS = 32;

  localparam int unsigned CW = 48;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_GAIN     = 2'd1,
    CMD_DISCOUNT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_CELL_SIZE  = 3'd2,
    REG_MAP_WIDTH  = 3'd3,
    REG_MAP_HEIGHT = 3'd4,
    REG_RADIUS     = 3'd5
  } reg_e;

  localparam logic [31:0] RST_CELL_SIZE  = 32'd3277;
  localparam logic [10:0] RST_MAP_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_MAP_HEIGHT = 11'd1024;
  localparam logic [31:0] RST_RADIUS     = 32'd65536;

  localparam logic [7:0]  CELL_UNKNOWN = 8'hFF;
  localparam logic [12:0] COUNT_MAX    = 13'h1FFF;
  localparam logic [47:0] AREA_MAX     = 48'hFFFF_FFFF_FFFF;

  function automatic logic [CW-1:0] abs_cw(input logic signed [CW-1:0] v);
    abs_cw = v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

endpackage

>>> hw/rtl/unknown_cell_disk_count_core.sv
// unknown cell disk counter: occupancy grid memory and window scan sequencer
//
// Usage: a command transaction is taken when start is high and busy is low.
// cmd write stores cell_value at cell_index in the grid memory in that cycle
// and gives no result; busy stays low. A gain or discount query raises busy,
// converts the point to a cell and the radius to cells with three shared
// bit-serial divides plus one for the window origin, then scans the window
// one cell a cycle through the grid memory: (2R+1) rows of (2R+1) cells with
// a setup state per row, R = radius / cell_size capped at MAX_RADIUS_CELLS.
// The result shows on unknown_count_o / unknown_area_o for exactly one cycle
// with result_valid_o high; the receiver cannot stall it. Busy falls in the
// same cycle. Configuration registers are written through cfg_valid_i /
// cfg_ready_o (always ready) while the block is idle, which the user must
// keep to: the block does not enforce it. Reset loads the register defaults
// and returns to idle; grid contents are undefined until written.
module unknown_cell_disk_count_core #(
  parameter int unsigned MAX_MAP_WIDTH    = ucdc_pkg::MAX_MAP_WIDTH,
  parameter int unsigned MAX_MAP_HEIGHT   = ucdc_pkg::MAX_MAP_HEIGHT,
  parameter int unsigned MAX_RADIUS_CELLS = ucdc_pkg::MAX_RADIUS_CELLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [19:0]        cell_index_i,
  input  logic signed [7:0]  cell_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] other_x_i,
  input  logic signed [31:0] other_y_i,
  output logic               result_valid_o,
  output logic [12:0]        unknown_count_o,
  output logic [47:0]        unknown_area_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned CW    = ucdc_pkg::CW;
  localparam int unsigned WW    = $clog2(MAX_MAP_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_MAP_HEIGHT + 1);
  localparam int unsigned DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RRW   = $clog2(MAX_RADIUS_CELLS + 1);
  localparam int unsigned KW    = RRW + 1;
  localparam int unsigned RW    = $clog2(MAX_MAP_HEIGHT + 2 * MAX_RADIUS_CELLS + 3) + 1;

  localparam logic signed [CW-1:0] ROW_LO = CW'(-(2 * int'(MAX_RADIUS_CELLS) + 2));
  localparam logic signed [CW-1:0] ROW_HI = CW'(MAX_MAP_HEIGHT);
  localparam logic [WW-1:0]  MAXW_C = WW'(MAX_MAP_WIDTH);
  localparam logic [HW-1:0]  MAXH_C = HW'(MAX_MAP_HEIGHT);
  localparam logic [RRW-1:0] MAXR_C = RRW'(MAX_RADIUS_CELLS);
  localparam logic [24:0]    DEPTH_C = 25'(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVX  = 4'd1;
  localparam logic [3:0] S_DIVY  = 4'd2;
  localparam logic [3:0] S_DIVR  = 4'd3;
  localparam logic [3:0] S_IDX   = 4'd4;
  localparam logic [3:0] S_INIT  = 4'd5;
  localparam logic [3:0] S_DIVI  = 4'd6;
  localparam logic [3:0] S_CX0   = 4'd7;
  localparam logic [3:0] S_ROW   = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_DRAIN = 4'd10;
  localparam logic [3:0] S_AREA1 = 4'd11;
  localparam logic [3:0] S_AREA2 = 4'd12;

  logic [3:0] state_q;

  logic signed [31:0] ox_q, oy_q;
  logic [31:0] csize_q, rad_q;
  logic [10:0] mw_q, mh_q;

  logic disc_q;
  logic signed [31:0] px_q, py_q, qx_q, qy_q;
  logic [31:0] res_q;
  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;

  logic [31:0] div_rem_q, div_den_q;
  logic [CW-1:0] div_quo_q;
  logic div_neg_q;
  logic [5:0] div_cnt_q;

  logic signed [CW-1:0] fx_q, fy_q, idx_q, init_q, size_q;
  logic signed [CW-1:0] rowraw_q, start_q, limb_q, cx0_q;
  logic [RRW-1:0] rr_q;
  logic [63:0] r2_q, sq_q;
  logic [WW-1:0] rf_q;
  logic [KW-1:0] n_q, k_q;
  logic dcnt_q;

  logic signed [CW-1:0] i_q, lim_q, cx_q, cy_q;
  logic [WW-1:0] col_q;

  logic [7:0] grid_mem [DEPTH];
  logic [7:0] rd_q;

  logic s1_v_q, s1_farp_q, s1_farq_q;
  logic [31:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic s2_v_q;
  logic [63:0] s2_x2p_q, s2_y2p_q, s2_x2q_q, s2_y2q_q;
  logic [12:0] count_q;
  logic [60:0] p1_q;
  logic [12:0] p2_q;
  logic result_valid_q;
  logic [12:0] count_out_q;
  logic [47:0] area_out_q;

  // command decode
  logic accept, is_query;
  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign is_query = (ucdc_pkg::cmd_e'(cmd_i) == ucdc_pkg::CMD_GAIN) ||
                    (ucdc_pkg::cmd_e'(cmd_i) == ucdc_pkg::CMD_DISCOUNT);

  logic [31:0] res_n;
  logic [WW-1:0] w_n;
  logic [HW-1:0] h_n;
  assign res_n = (csize_q == 32'd0) ? 32'd1 : csize_q;
  always_comb begin
    if (mw_q == 11'd0) begin
      w_n = WW'(1);
    end else if (32'(mw_q) > 32'(MAXW_C)) begin
      w_n = MAXW_C;
    end else begin
      w_n = WW'(mw_q);
    end
    if (32'(mh_q) > 32'(MAXH_C)) begin
      h_n = MAXH_C;
    end else begin
      h_n = HW'(mh_q);
    end
  end

  // bit-serial divider step and floor correction
  logic [32:0] rem_sh;
  logic ge;
  logic [31:0] rem_n;
  logic [CW-1:0] quo_n;
  logic signed [CW-1:0] q_floor;
  logic [31:0] r_floor;
  logic div_last;
  assign rem_sh   = {div_rem_q, div_quo_q[CW-1]};
  assign ge       = rem_sh >= {1'b0, div_den_q};
  assign rem_n    = ge ? 32'(rem_sh - {1'b0, div_den_q}) : rem_sh[31:0];
  assign quo_n    = {div_quo_q[CW-2:0], ge};
  assign div_last = (div_cnt_q == 6'(CW - 1));
  always_comb begin
    if (div_neg_q) begin
      q_floor = -$signed(quo_n) - ((rem_n != 32'd0) ? CW'(1) : CW'(0));
      r_floor = (rem_n != 32'd0) ? div_den_q - rem_n : 32'd0;
    end else begin
      q_floor = $signed(quo_n);
      r_floor = rem_n;
    end
  end

  // operands
  logic signed [CW-1:0] ox_x, oy_x, px_x, py_x, qx_x, qy_x, res_x, w_x, h_x;
  assign ox_x  = {{(CW-32){ox_q[31]}}, ox_q};
  assign oy_x  = {{(CW-32){oy_q[31]}}, oy_q};
  assign px_x  = {{(CW-32){px_q[31]}}, px_q};
  assign py_x  = {{(CW-32){py_q[31]}}, py_q};
  assign qx_x  = {{(CW-32){qx_q[31]}}, qx_q};
  assign qy_x  = {{(CW-32){qy_q[31]}}, qy_q};
  assign res_x = $signed({{(CW-32){1'b0}}, res_q});
  assign w_x   = $signed({{(CW-WW){1'b0}}, w_q});
  assign h_x   = $signed({{(CW-HW){1'b0}}, h_q});

  logic signed [CW-1:0] ax_in, ay_in, init_n, rf_x;
  assign ax_in  = {{(CW-32){point_x_i[31]}}, point_x_i} - ox_x;
  assign ay_in  = py_x - oy_x;
  assign init_n = idx_q - $signed({{(CW-RRW){1'b0}}, rr_q}) * (w_x + CW'(1));
  assign rf_x   = $signed({{(CW-32){1'b0}}, r_floor});

  // window row setup
  logic signed [CW-1:0] rowc_w;
  logic signed [RW-1:0] rowc;
  logic signed [CW-1:0] rowc_x;
  always_comb begin
    if (rowraw_q < ROW_LO) begin
      rowc_w = ROW_LO;
    end else if (rowraw_q > ROW_HI) begin
      rowc_w = ROW_HI;
    end else begin
      rowc_w = rowraw_q;
    end
  end
  assign rowc   = rowc_w[RW-1:0];
  assign rowc_x = {{(CW-RW){rowc[RW-1]}}, rowc};

  logic [KW-1:0] span;
  assign span = {rr_q, 1'b0};

  // per cell scan terms
  logic cell_ok, col_last;
  logic [AW-1:0] rd_addr;
  logic signed [CW-1:0] dxp, dyp, dxq, dyq;
  logic [CW-1:0] axp, ayp, axq, ayq, rad_x;
  assign cell_ok  = !i_q[CW-1] && (i_q < lim_q) && (i_q < size_q);
  assign col_last = (col_q == WW'(w_q - WW'(1)));
  assign rd_addr  = i_q[AW-1:0];
  assign dxp = px_x - cx_q;
  assign dyp = py_x - cy_q;
  assign dxq = qx_x - cx_q;
  assign dyq = qy_x - cy_q;
  assign axp = ucdc_pkg::abs_cw(dxp);
  assign ayp = ucdc_pkg::abs_cw(dyp);
  assign axq = ucdc_pkg::abs_cw(dxq);
  assign ayq = ucdc_pkg::abs_cw(dyq);
  assign rad_x = {{(CW-32){1'b0}}, rad_q};

  logic okp, okq, hit;
  assign okp = (s2_x2p_q <= r2_q) && (s2_y2p_q <= r2_q - s2_x2p_q);
  assign okq = (s2_x2q_q <= r2_q) && (s2_y2q_q <= r2_q - s2_x2q_q);
  assign hit = s2_v_q && okp && (!disc_q || okq);

  logic [61:0] area_sum;
  assign area_sum = {1'b0, p1_q} + 62'(p2_q);

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q    <= '0;
      oy_q    <= '0;
      csize_q <= ucdc_pkg::RST_CELL_SIZE;
      mw_q    <= ucdc_pkg::RST_MAP_WIDTH;
      mh_q    <= ucdc_pkg::RST_MAP_HEIGHT;
      rad_q   <= ucdc_pkg::RST_RADIUS;
    end else if (cfg_valid_i) begin
      unique case (ucdc_pkg::reg_e'(cfg_index_i))
        ucdc_pkg::REG_ORIGIN_X:   ox_q    <= cfg_data_i;
        ucdc_pkg::REG_ORIGIN_Y:   oy_q    <= cfg_data_i;
        ucdc_pkg::REG_CELL_SIZE:  csize_q <= cfg_data_i;
        ucdc_pkg::REG_MAP_WIDTH:  mw_q    <= cfg_data_i[10:0];
        ucdc_pkg::REG_MAP_HEIGHT: mh_q    <= cfg_data_i[10:0];
        ucdc_pkg::REG_RADIUS:     rad_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // grid memory
  logic [31:0] wr_idx;
  assign wr_idx = 32'(cell_index_i);
  always_ff @(posedge clk_i) begin
    if (accept && (ucdc_pkg::cmd_e'(cmd_i) == ucdc_pkg::CMD_WRITE) &&
        ({5'b0, cell_index_i} < DEPTH_C)) begin
      grid_mem[wr_idx[AW-1:0]] <= cell_value_i;
    end
    rd_q <= grid_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      div_cnt_q      <= '0;
      n_q            <= '0;
      k_q            <= '0;
      dcnt_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && is_query) begin
            disc_q    <= (ucdc_pkg::cmd_e'(cmd_i) == ucdc_pkg::CMD_DISCOUNT);
            px_q      <= point_x_i;
            py_q      <= point_y_i;
            qx_q      <= other_x_i;
            qy_q      <= other_y_i;
            res_q     <= res_n;
            w_q       <= w_n;
            h_q       <= h_n;
            div_neg_q <= ax_in[CW-1];
            div_quo_q <= ucdc_pkg::abs_cw(ax_in);
            div_rem_q <= '0;
            div_den_q <= res_n;
            div_cnt_q <= '0;
            state_q   <= S_DIVX;
          end
        end
        S_DIVX, S_DIVY, S_DIVR, S_DIVI: begin
          div_rem_q <= rem_n;
          div_quo_q <= quo_n;
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_last) begin
            div_cnt_q <= '0;
            div_rem_q <= '0;
            if (state_q == S_DIVX) begin
              fx_q      <= q_floor;
              div_neg_q <= ay_in[CW-1];
              div_quo_q <= ucdc_pkg::abs_cw(ay_in);
              state_q   <= S_DIVY;
            end else if (state_q == S_DIVY) begin
              fy_q      <= q_floor;
              div_neg_q <= 1'b0;
              div_quo_q <= {{(CW-32){1'b0}}, rad_q};
              state_q   <= S_DIVR;
            end else if (state_q == S_DIVR) begin
              rr_q    <= (quo_n > CW'(MAXR_C)) ? MAXR_C : quo_n[RRW-1:0];
              state_q <= S_IDX;
            end else begin
              rowraw_q <= q_floor;
              rf_q     <= r_floor[WW-1:0];
              start_q  <= init_q;
              limb_q   <= init_q - rf_x + (w_x <<< 1);
              n_q      <= '0;
              state_q  <= S_CX0;
            end
          end
        end
        S_IDX: begin
          idx_q   <= fy_q * w_x + fx_q;
          r2_q    <= 64'(rad_q) * 64'(rad_q);
          size_q  <= w_x * h_x;
          state_q <= S_INIT;
        end
        S_INIT: begin
          init_q    <= init_n;
          sq_q      <= 64'(res_q) * 64'(res_q);
          div_neg_q <= init_n[CW-1];
          div_quo_q <= ucdc_pkg::abs_cw(init_n);
          div_den_q <= 32'(w_q);
          state_q   <= S_DIVI;
        end
        S_CX0: begin
          cx0_q   <= ox_x + $signed(CW'(rf_q) * CW'(res_q));
          state_q <= S_ROW;
        end
        S_ROW: begin
          i_q     <= start_q;
          col_q   <= rf_q;
          cx_q    <= cx0_q;
          cy_q    <= oy_x + rowc_x * res_x;
          lim_q   <= limb_q + ((start_q[CW-1] && rf_q != '0) ? w_x : CW'(0));
          k_q     <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          i_q <= i_q + CW'(1);
          if (col_last) begin
            col_q <= '0;
            cx_q  <= ox_x;
            cy_q  <= cy_q + res_x;
          end else begin
            col_q <= col_q + WW'(1);
            cx_q  <= cx_q + res_x;
          end
          k_q <= k_q + KW'(1);
          if (k_q == span) begin
            if (n_q == span) begin
              dcnt_q  <= 1'b0;
              state_q <= S_DRAIN;
            end else begin
              n_q      <= n_q + KW'(1);
              start_q  <= start_q + w_x;
              rowraw_q <= rowraw_q + CW'(1);
              limb_q   <= limb_q + w_x;
              state_q  <= S_ROW;
            end
          end
        end
        S_DRAIN: begin
          dcnt_q <= 1'b1;
          if (dcnt_q) begin
            state_q <= S_AREA1;
          end
        end
        S_AREA1: begin
          p1_q    <= 61'(count_q) * 61'(sq_q[63:16]);
          p2_q    <= 13'((29'(count_q) * 29'(sq_q[15:0])) >> 16);
          state_q <= S_AREA2;
        end
        S_AREA2: begin
          count_out_q    <= count_q;
          area_out_q     <= (area_sum > 62'(ucdc_pkg::AREA_MAX)) ? ucdc_pkg::AREA_MAX :
                            area_sum[47:0];
          result_valid_q <= 1'b1;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // cell test pipeline: read and distance terms, squares, compare and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      count_q <= '0;
    end else begin
      s1_v_q    <= (state_q == S_SCAN) && cell_ok;
      s1_farp_q <= (axp > rad_x) || (ayp > rad_x);
      s1_farq_q <= (axq > rad_x) || (ayq > rad_x);
      s1_ax_q   <= axp[31:0];
      s1_ay_q   <= ayp[31:0];
      s1_bx_q   <= axq[31:0];
      s1_by_q   <= ayq[31:0];
      s2_v_q    <= s1_v_q && (rd_q == ucdc_pkg::CELL_UNKNOWN) && !s1_farp_q &&
                   (!disc_q || !s1_farq_q);
      s2_x2p_q  <= 64'(s1_ax_q) * 64'(s1_ax_q);
      s2_y2p_q  <= 64'(s1_ay_q) * 64'(s1_ay_q);
      s2_x2q_q  <= 64'(s1_bx_q) * 64'(s1_bx_q);
      s2_y2q_q  <= 64'(s1_by_q) * 64'(s1_by_q);
      if (state_q == S_CX0) begin
        count_q <= '0;
      end else if (hit && count_q != ucdc_pkg::COUNT_MAX) begin
        count_q <= count_q + 13'd1;
      end
    end
  end

  assign result_valid_o  = result_valid_q;
  assign unknown_count_o = count_out_q;
  assign unknown_area_o  = area_out_q;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the unknown cell disk counter core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ucdc_pkg::*;

  typedef struct {
    logic [12:0] cnt;
    logic [47:0] area;
  } gain_result_t;

  class gain_scoreboard;
    logic [7:0]        grid [int];
    longint            org_x, org_y;
    longint unsigned   cell_sz, map_w, map_h, rad;
    gain_result_t      pending_q [$];
    int                errors;

    function new();
      org_x   = 0;
      org_y   = 0;
      cell_sz = RST_CELL_SIZE;
      map_w   = RST_MAP_WIDTH;
      map_h   = RST_MAP_HEIGHT;
      rad     = RST_RADIUS;
      errors  = 0;
    endfunction

    function void set_reg(reg_e idx, logic [31:0] d);
      case (idx)
        REG_ORIGIN_X:   org_x = longint'(signed'(d));
        REG_ORIGIN_Y:   org_y = longint'(signed'(d));
        REG_CELL_SIZE:  cell_sz = d;
        REG_MAP_WIDTH:  map_w = d[10:0];
        REG_MAP_HEIGHT: map_h = d[10:0];
        REG_RADIUS:     rad = d;
        default: ;
      endcase
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function bit in_disk(longint px, longint py, longint cx, longint cy);
      longint unsigned ax, ay, r2, dx2, dy2;
      ax = (px < cx) ? longint'(cx - px) : longint'(px - cx);
      ay = (py < cy) ? longint'(cy - py) : longint'(py - cy);
      if (ax > rad || ay > rad) return 0;
      r2  = rad * rad;
      dx2 = ax * ax;
      dy2 = ay * ay;
      return (dx2 <= r2) && (dy2 <= r2 - dx2);
    endfunction

    function void note_item(cmd_e cmd, logic [19:0] ci, logic [7:0] cv,
                            logic signed [31:0] px_i, logic signed [31:0] py_i,
                            logic signed [31:0] qx_i, logic signed [31:0] qy_i);
      longint res, w, h, size, px, py, qx, qy, idx, rr, init, row_first, limit, cx, cy;
      longint unsigned cnt, sq, area;
      gain_result_t r;
      if (cmd == CMD_WRITE) begin
        grid[int'(ci)] = cv;
        return;
      end
      if (cmd != CMD_GAIN && cmd != CMD_DISCOUNT) return;
      res  = (cell_sz == 0) ? 1 : longint'(cell_sz);
      w    = (map_w == 0) ? 1 : ((map_w > MAX_MAP_WIDTH) ? MAX_MAP_WIDTH : longint'(map_w));
      h    = (map_h > MAX_MAP_HEIGHT) ? MAX_MAP_HEIGHT : longint'(map_h);
      size = w * h;
      px = px_i;
      py = py_i;
      qx = qx_i;
      qy = qy_i;
      idx = floor_div(py - org_y, res) * w + floor_div(px - org_x, res);
      rr  = longint'(rad / longint'(res));
      if (rr > MAX_RADIUS_CELLS) rr = MAX_RADIUS_CELLS;
      init = idx - rr * (w + 1);
      cnt  = 0;
      for (longint n = 0; n <= 2 * rr; n++) begin
        row_first = n * w + init;
        limit = (row_first / w + 2) * w;
        for (longint i = row_first; i <= row_first + 2 * rr; i++) begin
          if (i < 0 || i >= limit || i >= size) continue;
          if (grid[int'(i)] != CELL_UNKNOWN) continue;
          cx = org_x + (i % w) * res;
          cy = org_y + (i / w) * res;
          if (!in_disk(px, py, cx, cy)) continue;
          if (cmd == CMD_DISCOUNT && !in_disk(qx, qy, cx, cy)) continue;
          if (cnt < COUNT_MAX) cnt++;
        end
      end
      sq   = longint'(res) * longint'(res);
      area = cnt * (sq >> 16) + ((cnt * (sq & 64'hFFFF)) >> 16);
      if (area > AREA_MAX) area = AREA_MAX;
      r.cnt  = cnt[12:0];
      r.area = area[47:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [12:0] cnt, logic [47:0] area);
      gain_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: unknown_count %0d unknown_area %0d", cnt, area);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (cnt !== e.cnt) begin
        $error("unknown_count: expected %0d actual %0d", e.cnt, cnt);
        errors++;
      end
      if (area !== e.area) begin
        $error("unknown_area: expected %0d actual %0d", e.area, area);
        errors++;
      end
    endfunction
  endclass

  localparam int FILL_CELLS = 4096;
  localparam int WDOG_LIMIT = 30000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         cmd_i;
  logic [19:0]        cell_index_i;
  logic signed [7:0]  cell_value_i;
  logic signed [31:0] point_x_i, point_y_i, other_x_i, other_y_i;
  logic               result_valid_o;
  logic [12:0]        unknown_count_o;
  logic [47:0]        unknown_area_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  gain_scoreboard sb = new();
  bit             idle_en = 1;
  int             quiet_cycles = 0;

  unknown_cell_disk_count_core u_top (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (start && !busy) begin
        sb.note_item(cmd_e'(cmd_i), cell_index_i, cell_value_i,
                     point_x_i, point_y_i, other_x_i, other_y_i);
        quiet_cycles <= 0;
      end
      if (result_valid_o) begin
        sb.check_result(unknown_count_o, unknown_area_o);
        quiet_cycles <= 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_reg(reg_e'(cfg_index_i), cfg_data_i);
        quiet_cycles <= 0;
      end
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_item(cmd_e cmd, logic [19:0] ci, logic signed [7:0] cv,
                           logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] qx, logic signed [31:0] qy);
    if (idle_en && $urandom_range(99) < 34) begin
      start <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < 34);
    end
    start        <= 1;
    cmd_i        <= cmd;
    cell_index_i <= ci;
    cell_value_i <= cv;
    point_x_i    <= px;
    point_y_i    <= py;
    other_x_i    <= qx;
    other_y_i    <= qy;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_cell(int idx, logic signed [7:0] v);
    send_item(CMD_WRITE, idx[19:0], v, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic query(cmd_e cmd, longint px, longint py, longint qx, longint qy);
    send_item(cmd, $urandom, $urandom, px[31:0], py[31:0], qx[31:0], qy[31:0]);
  endtask

  // wait for every pending result and an idle block
  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(longint ox, longint oy, longint cs, longint w, longint h,
                           longint r);
    logic [31:0] vals [6];
    drain();
    vals = '{ox[31:0], oy[31:0], cs[31:0], w[31:0], h[31:0], r[31:0]};
    for (int k = 0; k < 6; k++) begin
      cfg_valid_i <= 1;
      cfg_index_i <= reg_e'(k);
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [7:0] rand_cell();
    return ($urandom_range(99) < 60) ? -8'sd1 : 8'($urandom_range(100));
  endfunction

  // random point mostly inside the current map, sometimes anywhere
  function automatic longint rand_coord(longint org, longint cells);
    longint res;
    res = (sb.cell_sz == 0) ? 1 : longint'(sb.cell_sz);
    if ($urandom_range(99) < 8) return longint'(signed'($urandom));
    return org + longint'($urandom_range(0, 1000)) * cells * res / 1000
           - longint'($urandom_range(0, 2)) * res;
  endfunction

  initial begin
    longint m, cs, w, h, px, py;
    rst_ni       = 0;
    start        = 0;
    cmd_i        = CMD_WRITE;
    cell_index_i = 0;
    cell_value_i = 0;
    point_x_i    = 0;
    point_y_i    = 0;
    other_x_i    = 0;
    other_y_i    = 0;
    cfg_valid_i  = 0;
    cfg_index_i  = REG_ORIGIN_X;
    cfg_data_i   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // every cell reachable by any map used below gets a known value
    for (int i = 0; i < FILL_CELLS; i++) write_cell(i, rand_cell());
    write_cell(20'hFFFFF, 8'sd100);

    // directed
    m = 65536;
    configure(0, 0, m, 64, 64, 5 * m);
    query(CMD_GAIN, 10 * m, 10 * m, 0, 0);
    query(CMD_GAIN, 0, 0, 0, 0);
    query(CMD_GAIN, -7 * m / 2, -2 * m, 0, 0);
    query(CMD_DISCOUNT, 10 * m, 10 * m, 12 * m, 10 * m);
    query(CMD_DISCOUNT, 10 * m, 10 * m, 30 * m, 30 * m);
    query(CMD_DISCOUNT, 20 * m, 20 * m, 20 * m, 20 * m);
    query(CMD_GAIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    query(CMD_DISCOUNT, -32'sh8000_0000, -32'sh8000_0000, 32'h7FFF_FFFF, 0);
    configure(-5 * m, 3 * m, m / 2, 64, 64, 40 * (m / 2));
    query(CMD_GAIN, 10 * m, 15 * m, 0, 0);
    query(CMD_DISCOUNT, 10 * m, 15 * m, 12 * m, 17 * m);
    configure(-32'sh8000_0000, 32'h7FFF_FFFF, 1, 1024, 4, 32'hFFFF_FFFF);
    query(CMD_GAIN, -32'sh8000_0000 + 40, 32'h7FFF_FFFF, 0, 0);
    configure(0, 0, 0, 0, 2047, 3);
    query(CMD_GAIN, 0, 500, 0, 0);
    configure(0, 0, 32'hFFFF_FFFF, 2047, 0, 32'h7FFF_FFFF);
    query(CMD_GAIN, 0, 0, 0, 0);
    configure(m, m, m, 1, 1, 2 * m);
    query(CMD_GAIN, m, m, 0, 0);
    query(CMD_DISCOUNT, m, m, m + 1, m);

    // random phases of small maps
    for (int ph = 0; ph < 13; ph++) begin
      w  = $urandom_range(1, 64);
      h  = $urandom_range(1, 64);
      cs = $urandom_range(1000, 200000);
      configure(longint'($urandom_range(0, 2 ** 21)) - 2 ** 20,
                longint'($urandom_range(0, 2 ** 21)) - 2 ** 20,
                cs, w, h, cs * $urandom_range(0, 6) + $urandom_range(0, cs - 1));
      idle_en = (ph != 4);
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(99) < 30) begin
          write_cell((k == 0) ? $urandom_range(0, 20'hFFFFF)
                              : $urandom_range(0, int'(w * h) - 1), rand_cell());
        end else begin
          px = rand_coord(sb.org_x, w);
          py = rand_coord(sb.org_y, h);
          if ($urandom_range(1))
            query(CMD_GAIN, px, py, $urandom, $urandom);
          else
            query(CMD_DISCOUNT, px, py, px + longint'($urandom_range(0, 4 * cs)) - 2 * cs,
                  py + longint'($urandom_range(0, 4 * cs)) - 2 * cs);
        end
      end
    end
    idle_en = 1;

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
